// File: hdl/sqd_pkg.sv
// Shared types and constants for the stack/queue/deque unit.
package sqd_pkg;

	localparam int DEPTH = 1024;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = 11;
	localparam int DW    = 32;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [DW-1:0] wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic          ld;
		logic          sel_mem;
		status_t       status;
		logic [CW-1:0] count;
	} res_t;

endpackage

// File: hdl/stack_queue_deque_unit.sv
// Stack/queue/deque unit: bounded double-ended store of 32-bit words.
//
// Input channel (in_valid/in_ready, op, data): one operation per transaction:
// push on top, insert at bottom, pop top, or clear. Output channel
// (out_valid/out_ready, value, status, is_empty, count): exactly one result
// transaction per input transaction, in order.
// Words live in a 1024-entry ring buffer RAM with a registered read.
// Push, insert and clear update the pointers and at most one RAM entry in the
// accept cycle; the result appears in the output register on the next cycle.
// A successful pop reads the RAM, so its result goes through the RAM read
// register; no new transaction is taken in the cycle after its accept.
// Throughput: one transaction per cycle for push, insert, clear and empty
// pops while results are taken; none while a successful pop's read is pending.
// A new transaction is accepted while the output register holds a result only
// if that result is taken in the same cycle; a stalled receiver therefore
// holds off the input after one buffered result.
// Reset (arst_n low) empties the store; RAM contents are not cleared and no
// clearing pass is needed.
module stack_queue_deque_unit import sqd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  logic signed [DW-1:0] data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [DW-1:0] value,
	output logic [1:0]           status,
	output logic                 is_empty,
	output logic [CW-1:0]        count
);

	mem_req_t      mreq;
	res_t          res;
	logic [DW-1:0] rdata;

	logic          out_valid_q;
	logic [DW-1:0] value_q;
	logic [1:0]    status_q;
	logic [CW-1:0] count_q;

	sqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.data      (data),
		.slot_free (!out_valid_q || out_ready),
		.mreq      (mreq),
		.res       (res)
	);

	sqd_ram #(
		.WIDTH  (DW),
		.ADDR_W (AW),
		.WORDS  (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.ld) begin
			value_q  <= res.sel_mem ? rdata : '0;
			status_q <= res.status;
			count_q  <= res.count;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;
	assign count     = count_q;
	assign is_empty  = (count_q == '0);

endmodule

// File: hdl/sqd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
module sqd_ram #(
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 10,
	parameter int WORDS  = 1024
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/sqd_ctrl.sv
// Pointer and count control: decodes transactions and drives the RAM.
module sqd_ctrl import sqd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    op,
	input  logic [DW-1:0] data,
	input  logic          slot_free,
	output mem_req_t      mreq,
	output res_t          res
);

	logic [AW-1:0] bot_q;
	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic [CW-1:0] pcnt_q;

	logic          acc;
	logic          full;
	logic          empty;
	op_t           op_c;
	logic [CW-1:0] off;
	logic [AW:0]   sum;
	logic [AW-1:0] top_pos;
	logic [AW-1:0] bot_dec;

	assign in_ready = !pend_q && slot_free;
	assign acc      = in_valid && in_ready;
	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign op_c     = op_t'(op);

	always_comb begin
		off = (op_c == OP_POP) ? cnt_q - CW'(1) : cnt_q;
		sum = {1'b0, bot_q} + {1'b0, off[AW-1:0]};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		top_pos = sum[AW-1:0];
		bot_dec = (bot_q == '0) ? AW'(DEPTH - 1) : bot_q - AW'(1);
	end

	always_comb begin
		mreq.we    = 1'b0;
		mreq.waddr = top_pos;
		mreq.wdata = data;
		mreq.re    = 1'b0;
		mreq.raddr = top_pos;
		res.ld      = 1'b0;
		res.sel_mem = 1'b0;
		res.status  = ST_OK;
		res.count   = cnt_q;
		if (pend_q) begin
			res.ld      = 1'b1;
			res.sel_mem = 1'b1;
			res.count   = pcnt_q;
		end else if (acc) begin
			case (op_c)
				OP_PUSH, OP_INSERT: begin
					res.ld = 1'b1;
					if (full) begin
						res.status = ST_OVERFLOW;
					end else begin
						mreq.we    = 1'b1;
						mreq.waddr = (op_c == OP_PUSH) ? top_pos : bot_dec;
						res.count  = cnt_q + CW'(1);
					end
				end
				OP_POP: begin
					if (empty) begin
						res.ld     = 1'b1;
						res.status = ST_UNDERFLOW;
					end else begin
						mreq.re = 1'b1;
					end
				end
				default: begin
					res.ld    = 1'b1;
					res.count = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bot_q  <= '0;
			cnt_q  <= '0;
			pend_q <= 1'b0;
			pcnt_q <= '0;
		end else begin
			pend_q <= 1'b0;
			if (acc) begin
				case (op_c)
					OP_PUSH: begin
						if (!full) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
					OP_INSERT: begin
						if (!full) begin
							cnt_q <= cnt_q + CW'(1);
							bot_q <= bot_dec;
						end
					end
					OP_POP: begin
						if (!empty) begin
							cnt_q  <= cnt_q - CW'(1);
							pcnt_q <= cnt_q - CW'(1);
							pend_q <= 1'b1;
						end
					end
					default: begin
						cnt_q <= '0;
						bot_q <= '0;
					end
				endcase
			end
		end
	end

endmodule

// File: test/stack_queue_deque_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_queue_deque_unit: directed table, then random traffic.
module stack_queue_deque_unit_tb import sqd_pkg::*; ();

	localparam int STALL_LIMIT = 4000;
	localparam int N_ROWS = 22;

	typedef struct packed {
		logic [DW-1:0] value;
		status_t       status;
		logic          is_empty;
		logic [CW-1:0] count;
	} outcome_t;

	typedef struct packed {
		op_t           op;
		logic [DW-1:0] data;
		logic          has_want;
		outcome_t      want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	op_t                  op = OP_PUSH;
	logic [DW-1:0]        data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [DW-1:0] value;
	logic [1:0]           status;
	logic                 is_empty;
	logic [CW-1:0]        count;

	logic [DW-1:0] word_mirror [DEPTH];
	int unsigned   bottom_pos = 0;
	int unsigned   held = 0;
	outcome_t      outcome_q [$];
	int            src_idle_pct = 34;
	int            sink_idle_pct = 70;
	int            err_cnt = 0;
	int            stall_cycles = 0;
	dir_row_t      dir_rows [N_ROWS];

	stack_queue_deque_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.data     (data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.status   (status),
		.is_empty (is_empty),
		.count    (count)
	);

	always #4 clk = ~clk;

	function automatic outcome_t apply_op(op_t o, logic [DW-1:0] d);
		outcome_t r;
		r = '0;
		r.status = ST_OK;
		case (o)
		OP_PUSH, OP_INSERT: begin
			if (held >= DEPTH) begin
				r.status = ST_OVERFLOW;
			end else if (o == OP_PUSH) begin
				word_mirror[(bottom_pos + held) % DEPTH] = d;
				held++;
			end else begin
				bottom_pos = (bottom_pos == 0) ? DEPTH - 1 : bottom_pos - 1;
				word_mirror[bottom_pos] = d;
				held++;
			end
		end
		OP_POP: begin
			if (held == 0) begin
				r.status = ST_UNDERFLOW;
			end else begin
				r.value = word_mirror[(bottom_pos + held - 1) % DEPTH];
				held--;
			end
		end
		default: begin
			held = 0;
			bottom_pos = 0;
		end
		endcase
		r.is_empty = (held == 0);
		r.count = CW'(held);
		return r;
	endfunction

	function automatic op_t pick_op();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 36) return OP_PUSH;
		if (roll < 66) return OP_INSERT;
		if (roll < 95) return OP_POP;
		return OP_CLEAR;
	endfunction

	function automatic logic [DW-1:0] pick_word();
		case ($urandom_range(11))
		0: return 32'h0000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'h8000_0000;
		3: return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	task automatic send_op(op_t o, logic [DW-1:0] d, logic has_want, outcome_t want);
		outcome_t got;
		if ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		in_valid <= 1'b1;
		op <= o;
		data <= d;
		do @(posedge clk); while (!in_ready);
		got = apply_op(o, d);
		outcome_q.push_back(has_want ? want : got);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (outcome_q.size() == 0) begin
				$error("result with no transaction pending: value %h status %0d count %0d",
					value, status, count);
				err_cnt++;
			end else begin
				want = outcome_q.pop_front();
				if (value !== want.value) begin
					$error("value: expected %h, got %h", want.value, value);
					err_cnt++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					err_cnt++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
					err_cnt++;
				end
				if (count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, count);
					err_cnt++;
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL stack_queue_deque_unit");
			$finish;
		end
	end

	initial begin
		dir_rows = '{
			'{OP_POP,    32'hDEAD_BEEF, 1'b1, '{32'h0000_0000, ST_UNDERFLOW, 1'b1, 11'd0}},
			'{OP_CLEAR,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd0}},
			'{OP_PUSH,   32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd1}},
			'{OP_PUSH,   32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd2}},
			'{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd3}},
			'{OP_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd4}},
			'{OP_POP,    32'h7FFF_FFFF, 1'b1, '{32'h8000_0000, ST_OK,        1'b0, 11'd3}},
			'{OP_POP,    32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,        1'b0, 11'd2}},
			'{OP_POP,    32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK,        1'b0, 11'd1}},
			'{OP_POP,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd0}},
			'{OP_POP,    32'h0000_0000, 1'b1, '{32'h0000_0000, ST_UNDERFLOW, 1'b1, 11'd0}},
			'{OP_INSERT, 32'h1234_5678, 1'b0, '0},
			'{OP_PUSH,   32'hA5A5_A5A5, 1'b0, '0},
			'{OP_INSERT, 32'h5A5A_5A5A, 1'b0, '0},
			'{OP_POP,    32'hFFFF_FFFF, 1'b0, '0},
			'{OP_INSERT, 32'h0F0F_0F0F, 1'b0, '0},
			'{OP_CLEAR,  32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd0}},
			'{OP_INSERT, 32'h5555_5555, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd1}},
			'{OP_POP,    32'h0000_0000, 1'b1, '{32'h5555_5555, ST_OK,        1'b1, 11'd0}},
			'{OP_PUSH,   32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd1}},
			'{OP_POP,    32'h0000_0000, 1'b1, '{32'hAAAA_AAAA, ST_OK,        1'b1, 11'd0}},
			'{OP_CLEAR,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd0}}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i].op, dir_rows[i].data, dir_rows[i].has_want, dir_rows[i].want);

		repeat (30) send_op(pick_op(), pick_word(), 1'b0, '0);

		src_idle_pct = 70;
		sink_idle_pct = 34;
		repeat (30) send_op(pick_op(), pick_word(), 1'b0, '0);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		send_op(OP_CLEAR, pick_word(), 1'b0, '0);
		// fill to full with both ends, then hit overflow from both ends
		while (held < DEPTH)
			send_op(($urandom_range(49) == 0) ? OP_POP :
				($urandom_range(1) ? OP_PUSH : OP_INSERT), pick_word(), 1'b0, '0);
		repeat (6) send_op($urandom_range(1) ? OP_PUSH : OP_INSERT, pick_word(), 1'b0, '0);
		send_op(OP_POP, pick_word(), 1'b0, '0);
		send_op(OP_INSERT, pick_word(), 1'b0, '0);
		send_op(OP_PUSH, pick_word(), 1'b0, '0);
		send_op(OP_INSERT, pick_word(), 1'b0, '0);
		repeat (20) send_op(OP_POP, pick_word(), 1'b0, '0);
		send_op(OP_CLEAR, pick_word(), 1'b0, '0);
		repeat (20) send_op(pick_op(), pick_word(), 1'b0, '0);

		in_valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0 && outcome_q.size() == 0)
			$display("PASS stack_queue_deque_unit");
		else
			$display("FAIL stack_queue_deque_unit");
		$finish;
	end

endmodule
